// ===== rtl/gtc_pkg.sv =====
// Package for the greenhouse threshold controller.
// Holds the field widths, register indexes, reset values and the shared run-counter step.
// No dependencies.
`default_nettype none

package gtc_pkg;

    localparam int TempW    = 15;
    localparam int HumW     = 14;
    localparam int Co2W     = 17;
    localparam int ReadW    = 18;
    localparam int RunW     = 8;
    localparam int CfgW     = 17;
    localparam int CfgAddrW = 3;

    // Register indexes on the configuration port.
    localparam logic [CfgAddrW-1:0] REG_MIN_TEMP = 3'd0;
    localparam logic [CfgAddrW-1:0] REG_MAX_TEMP = 3'd1;
    localparam logic [CfgAddrW-1:0] REG_MIN_HUM  = 3'd2;
    localparam logic [CfgAddrW-1:0] REG_MAX_HUM  = 3'd3;
    localparam logic [CfgAddrW-1:0] REG_MIN_CO2  = 3'd4;
    localparam logic [CfgAddrW-1:0] REG_MAX_CO2  = 3'd5;
    localparam logic [CfgAddrW-1:0] REG_PERSIST  = 3'd6;

    // Sensor sources carried in tuser.
    localparam logic [1:0] REQ_TEMP = 2'd0;
    localparam logic [1:0] REQ_HUM  = 2'd1;
    localparam logic [1:0] REQ_CO2  = 2'd2;

    localparam logic signed [TempW-1:0] RST_MIN_TEMP = 15'sd1500;
    localparam logic signed [TempW-1:0] RST_MAX_TEMP = 15'sd3500;
    localparam logic [HumW-1:0]         RST_MIN_HUM  = 14'd1500;
    localparam logic [HumW-1:0]         RST_MAX_HUM  = 14'd3500;
    localparam logic [Co2W-1:0]         RST_MIN_CO2  = 17'd3000;
    localparam logic [Co2W-1:0]         RST_MAX_CO2  = 17'd6000;
    localparam logic [RunW-1:0]         RST_PERSIST  = 8'd10;

    // Actuator flag and run counter of one channel.
    typedef struct packed {
        logic            flag;
        logic [RunW-1:0] run;
    } gtc_chan_t;

    typedef struct packed {
        logic            fire;
        logic [RunW-1:0] run;
    } gtc_bump_t;

    // Count one out-of-limit reading; the counter saturates at its top and
    // returns to zero when it reaches the persist count.
    function automatic gtc_bump_t gtc_bump(input logic [RunW-1:0] run,
                                           input logic [RunW-1:0] persist);
        logic [RunW-1:0] inc;
        gtc_bump_t       res;
        inc = (run == {RunW{1'b1}}) ? run : run + 1'b1;
        if (inc >= persist)
        begin
            res.fire = 1'b1;
            res.run  = '0;
        end
        else
        begin
            res.fire = 1'b0;
            res.run  = inc;
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/gtc_low_chan.sv =====
// Low-limit channel update shared by humidity and CO2.
// Depends on gtc_pkg for the channel state type and the run-counter step.
`default_nettype none

module gtc_low_chan (
    input  wire logic                                   enable,
    input  wire logic signed [gtc_pkg::ReadW-1:0]       reading,
    input  wire logic signed [gtc_pkg::ReadW-1:0]       lo_limit,
    input  wire logic signed [gtc_pkg::ReadW-1:0]       hi_limit,
    input  wire logic [gtc_pkg::RunW-1:0]               persist,
    input  wire gtc_pkg::gtc_chan_t                     cur,
    output gtc_pkg::gtc_chan_t                          nxt
);

    logic signed [gtc_pkg::ReadW+1:0] twice;
    logic signed [gtc_pkg::ReadW+1:0] mid_sum;
    gtc_pkg::gtc_bump_t               step;

    assign twice   = {reading[gtc_pkg::ReadW-1], reading, 1'b0};
    assign mid_sum = {{2{lo_limit[gtc_pkg::ReadW-1]}}, lo_limit}
                   + {{2{hi_limit[gtc_pkg::ReadW-1]}}, hi_limit};
    assign step    = gtc_pkg::gtc_bump(cur.run, persist);

    always_comb
    begin
        nxt = cur;
        if (enable)
        begin
            if (reading < lo_limit)
            begin
                if (!cur.flag)
                begin
                    nxt.run = step.run;
                    if (step.fire)
                    begin
                        nxt.flag = 1'b1;
                    end
                end
            end
            else
            begin
                nxt.run = '0;
            end
            // Midpoint turn-off may undo a turn-on of the same reading.
            if (twice > mid_sum)
            begin
                nxt.flag = 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/greenhouse_threshold_controller_top.sv =====
// Greenhouse threshold controller: bang-bang control of four actuators with hysteresis.
// Each item passes through the input register and then the result register before m_tvalid rises.
// Throughput: one item per cycle; both registers advance together, so the rate is limited only by m_tready.
// Reset (rst_n low, asynchronous): actuators off, run counters and held readings zero,
// limits and persist count at their default values, both stages empty.
// Depends on gtc_pkg and gtc_low_chan.
`default_nettype none

module greenhouse_threshold_controller_top (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    // Sensor items.
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [23:0]                      s_tdata,  // [17:0] reading, zero fill above
    input  wire logic [1:0]                       s_tuser,  // [1:0] req_type
    // Result items.
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // [0] heater_on, [1] cooler_on, [2] irrigator_on, [3] injector_on, [7:4] switch_mask,
    // [22:8] recent_temperature, [36:23] recent_humidity, [53:37] recent_co2, zero fill above
    output logic [55:0]                           m_tdata,
    // Configuration writes.
    input  wire logic                             cfg_wr_en,
    input  wire logic [gtc_pkg::CfgAddrW-1:0]     cfg_addr,
    input  wire logic [gtc_pkg::CfgW-1:0]         cfg_wdata
);

    localparam int TW = gtc_pkg::TempW;
    localparam int HW = gtc_pkg::HumW;
    localparam int CW = gtc_pkg::Co2W;
    localparam int RW = gtc_pkg::ReadW;

    // Configuration registers.
    logic signed [TW-1:0]         min_temp_reg;
    logic signed [TW-1:0]         max_temp_reg;
    logic [HW-1:0]                min_hum_reg;
    logic [HW-1:0]                max_hum_reg;
    logic [CW-1:0]                min_co2_reg;
    logic [CW-1:0]                max_co2_reg;
    logic [gtc_pkg::RunW-1:0]     persist_reg;

    // Input stage.
    logic                         in_valid_reg;
    logic [1:0]                   in_type_reg;
    logic signed [RW-1:0]         in_reading_reg;

    // Controller state.
    logic                         heater_reg;
    logic                         cooler_reg;
    logic [gtc_pkg::RunW-1:0]     temp_run_reg;
    gtc_pkg::gtc_chan_t           hum_reg;
    gtc_pkg::gtc_chan_t           co2_reg;
    logic signed [TW-1:0]         held_temp_reg;
    logic [HW-1:0]                held_hum_reg;
    logic [CW-1:0]                held_co2_reg;

    logic                         heater_next;
    logic                         cooler_next;
    logic [gtc_pkg::RunW-1:0]     temp_run_next;
    gtc_pkg::gtc_chan_t           hum_next;
    gtc_pkg::gtc_chan_t           co2_next;
    logic signed [TW-1:0]         held_temp_next;
    logic [HW-1:0]                held_hum_next;
    logic [CW-1:0]                held_co2_next;

    // Result stage.
    logic                         out_valid_reg;
    logic [55:0]                  out_data_reg;
    logic [55:0]                  out_data_next;

    logic                         advance;
    logic signed [RW+1:0]         twice;
    logic signed [RW+1:0]         temp_sum;
    logic signed [RW-1:0]         min_temp_w;
    logic signed [RW-1:0]         max_temp_w;
    gtc_pkg::gtc_bump_t           temp_step;
    logic [3:0]                   switch_mask;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // Configuration port.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_temp_reg <= gtc_pkg::RST_MIN_TEMP;
            max_temp_reg <= gtc_pkg::RST_MAX_TEMP;
            min_hum_reg  <= gtc_pkg::RST_MIN_HUM;
            max_hum_reg  <= gtc_pkg::RST_MAX_HUM;
            min_co2_reg  <= gtc_pkg::RST_MIN_CO2;
            max_co2_reg  <= gtc_pkg::RST_MAX_CO2;
            persist_reg  <= gtc_pkg::RST_PERSIST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_addr)
                gtc_pkg::REG_MIN_TEMP: min_temp_reg <= cfg_wdata[TW-1:0];
                gtc_pkg::REG_MAX_TEMP: max_temp_reg <= cfg_wdata[TW-1:0];
                gtc_pkg::REG_MIN_HUM:  min_hum_reg  <= cfg_wdata[HW-1:0];
                gtc_pkg::REG_MAX_HUM:  max_hum_reg  <= cfg_wdata[HW-1:0];
                gtc_pkg::REG_MIN_CO2:  min_co2_reg  <= cfg_wdata[CW-1:0];
                gtc_pkg::REG_MAX_CO2:  max_co2_reg  <= cfg_wdata[CW-1:0];
                gtc_pkg::REG_PERSIST:  persist_reg  <= cfg_wdata[gtc_pkg::RunW-1:0];
                default: ;
            endcase
        end
    end

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_type_reg    <= s_tuser;
            in_reading_reg <= s_tdata[RW-1:0];
        end
    end

    // Temperature channel.
    assign min_temp_w = {{(RW-TW){min_temp_reg[TW-1]}}, min_temp_reg};
    assign max_temp_w = {{(RW-TW){max_temp_reg[TW-1]}}, max_temp_reg};
    assign twice      = {in_reading_reg[RW-1], in_reading_reg, 1'b0};
    assign temp_sum   = {{2{min_temp_w[RW-1]}}, min_temp_w}
                      + {{2{max_temp_w[RW-1]}}, max_temp_w};
    assign temp_step  = gtc_pkg::gtc_bump(temp_run_reg, persist_reg);

    always_comb
    begin
        heater_next    = heater_reg;
        cooler_next    = cooler_reg;
        temp_run_next  = temp_run_reg;
        held_temp_next = held_temp_reg;
        if (in_type_reg == gtc_pkg::REQ_TEMP)
        begin
            // Saturate the held value to the 15-bit signed field.
            if (in_reading_reg[RW-1:TW-1] == '0 || in_reading_reg[RW-1:TW-1] == '1)
            begin
                held_temp_next = in_reading_reg[TW-1:0];
            end
            else if (in_reading_reg[RW-1])
            begin
                held_temp_next = {1'b1, {(TW-1){1'b0}}};
            end
            else
            begin
                held_temp_next = {1'b0, {(TW-1){1'b1}}};
            end

            if (in_reading_reg > max_temp_w && !cooler_reg)
            begin
                temp_run_next = temp_step.run;
                if (temp_step.fire)
                begin
                    cooler_next = 1'b1;
                end
            end
            else if (in_reading_reg < min_temp_w && !heater_reg)
            begin
                temp_run_next = temp_step.run;
                if (temp_step.fire)
                begin
                    heater_next = 1'b1;
                end
            end
            else if (in_reading_reg >= min_temp_w && in_reading_reg <= max_temp_w)
            begin
                temp_run_next = '0;
            end

            if (twice < temp_sum)
            begin
                cooler_next = 1'b0;
            end
            if (twice > temp_sum)
            begin
                heater_next = 1'b0;
            end
        end
    end

    // Humidity and CO2 channels.
    gtc_low_chan u_hum_chan (
        .enable   (in_type_reg == gtc_pkg::REQ_HUM),
        .reading  (in_reading_reg),
        .lo_limit ({{(RW-HW){1'b0}}, min_hum_reg}),
        .hi_limit ({{(RW-HW){1'b0}}, max_hum_reg}),
        .persist  (persist_reg),
        .cur      (hum_reg),
        .nxt      (hum_next)
    );

    gtc_low_chan u_co2_chan (
        .enable   (in_type_reg == gtc_pkg::REQ_CO2),
        .reading  (in_reading_reg),
        .lo_limit ({{(RW-CW){1'b0}}, min_co2_reg}),
        .hi_limit ({{(RW-CW){1'b0}}, max_co2_reg}),
        .persist  (persist_reg),
        .cur      (co2_reg),
        .nxt      (co2_next)
    );

    always_comb
    begin
        held_hum_next = held_hum_reg;
        held_co2_next = held_co2_reg;
        if (in_type_reg == gtc_pkg::REQ_HUM)
        begin
            if (in_reading_reg[RW-1])
            begin
                held_hum_next = '0;
            end
            else if (in_reading_reg[RW-2:HW] != '0)
            begin
                held_hum_next = '1;
            end
            else
            begin
                held_hum_next = in_reading_reg[HW-1:0];
            end
        end
        if (in_type_reg == gtc_pkg::REQ_CO2)
        begin
            held_co2_next = in_reading_reg[RW-1] ? '0 : in_reading_reg[CW-1:0];
        end
    end

    assign switch_mask = {co2_reg.flag ^ co2_next.flag,
                          hum_reg.flag ^ hum_next.flag,
                          cooler_reg ^ cooler_next,
                          heater_reg ^ heater_next};

    assign out_data_next = {2'b00, held_co2_next, held_hum_next, held_temp_next,
                            switch_mask, co2_next.flag, hum_next.flag,
                            cooler_next, heater_next};

    // State and result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            heater_reg    <= 1'b0;
            cooler_reg    <= 1'b0;
            temp_run_reg  <= '0;
            hum_reg       <= '0;
            co2_reg       <= '0;
            held_temp_reg <= '0;
            held_hum_reg  <= '0;
            held_co2_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            heater_reg    <= heater_next;
            cooler_reg    <= cooler_next;
            temp_run_reg  <= temp_run_next;
            hum_reg       <= hum_next;
            co2_reg       <= co2_next;
            held_temp_reg <= held_temp_next;
            held_hum_reg  <= held_hum_next;
            held_co2_reg  <= held_co2_next;
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_data_reg <= out_data_next;
        end
    end

endmodule

`default_nettype wire

// ===== sim/actuator_checker.sv =====
// Checker for the greenhouse threshold controller: watches the sensor, result and
// configuration ports, predicts each result item and compares it field by field.
// Depends on gtc_pkg for widths, register indexes, sensor codes and reset values.
module actuator_checker
    import gtc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    input  logic                s_tready,
    input  logic [23:0]         s_tdata,
    input  logic [1:0]          s_tuser,
    input  logic                m_tvalid,
    input  logic                m_tready,
    input  logic [55:0]         m_tdata,
    input  logic                cfg_wr_en,
    input  logic [CfgAddrW-1:0] cfg_addr,
    input  logic [CfgW-1:0]     cfg_wdata,
    output int                  mismatch_count,
    output int                  outstanding
);

    typedef struct packed {
        logic                    heater;
        logic                    cooler;
        logic                    irrigator;
        logic                    injector;
        logic [3:0]              switched;
        logic signed [TempW-1:0] temp;
        logic [HumW-1:0]         hum;
        logic [Co2W-1:0]         co2;
    } actuation_t;

    actuation_t pending_actuations[$];
    int errs;

    // Limits as the block holds them.
    logic signed [TempW-1:0] t_lo, t_hi;
    logic [HumW-1:0]         h_lo, h_hi;
    logic [Co2W-1:0]         c_lo, c_hi;
    logic [RunW-1:0]         persist_need;

    logic                    heater, cooler, irrigator, injector;
    logic [RunW-1:0]         t_run, h_run, c_run;
    logic signed [TempW-1:0] held_t;
    logic [HumW-1:0]         held_h;
    logic [Co2W-1:0]         held_c;

    function automatic int saturate(int v, int floor_v, int ceil_v);
        if (v < floor_v)
            return floor_v;
        if (v > ceil_v)
            return ceil_v;
        return v;
    endfunction

    // Returns {turn_on, new_count} for one more out-of-limit reading.
    function automatic logic [RunW:0] advance_run(logic [RunW-1:0] run);
        logic [RunW-1:0] n;
        n = (run < 8'd255) ? run + 8'd1 : run;
        if (n >= persist_need)
            return {1'b1, 8'd0};
        return {1'b0, n};
    endfunction

    // Humidity and CO2 turn on only below the lower limit; the off point is the midpoint of both.
    function automatic logic [RunW:0] low_limit_step(int r, int lo, int hi, logic flag,
                                                     logic [RunW-1:0] run);
        logic [RunW:0]   adv;
        logic            f;
        logic [RunW-1:0] n;
        f = flag;
        n = run;
        if (r < lo)
        begin
            if (!f)
            begin
                adv = advance_run(n);
                n   = adv[RunW-1:0];
                if (adv[RunW])
                    f = 1'b1;
            end
        end
        else
            n = '0;
        if (2 * r > lo + hi)
            f = 1'b0;
        return {f, n};
    endfunction

    function automatic actuation_t predict_actuation(logic [1:0] kind,
                                                     logic signed [ReadW-1:0] rd);
        actuation_t    res;
        logic [RunW:0] adv;
        logic          was_h, was_c, was_i, was_j;
        int            r, lo, hi;
        r     = int'(rd);
        was_h = heater;
        was_c = cooler;
        was_i = irrigator;
        was_j = injector;
        case (kind)
            REQ_TEMP:
            begin
                lo     = int'(t_lo);
                hi     = int'(t_hi);
                held_t = 15'(saturate(r, -16384, 16383));
                if (r > hi && !cooler)
                begin
                    adv   = advance_run(t_run);
                    t_run = adv[RunW-1:0];
                    if (adv[RunW])
                        cooler = 1'b1;
                end
                else if (r < lo && !heater)
                begin
                    adv   = advance_run(t_run);
                    t_run = adv[RunW-1:0];
                    if (adv[RunW])
                        heater = 1'b1;
                end
                else if (r >= lo && r <= hi)
                    t_run = '0;
                if (2 * r < lo + hi)
                    cooler = 1'b0;
                if (2 * r > lo + hi)
                    heater = 1'b0;
            end
            REQ_HUM:
            begin
                held_h = 14'(saturate(r, 0, 16383));
                adv    = low_limit_step(r, int'(h_lo), int'(h_hi), irrigator, h_run);
                {irrigator, h_run} = adv;
            end
            REQ_CO2:
            begin
                held_c = 17'(saturate(r, 0, 131071));
                adv    = low_limit_step(r, int'(c_lo), int'(c_hi), injector, c_run);
                {injector, c_run} = adv;
            end
            default: ;
        endcase
        res.heater    = heater;
        res.cooler    = cooler;
        res.irrigator = irrigator;
        res.injector  = injector;
        res.switched  = {was_j != injector, was_i != irrigator, was_c != cooler,
                         was_h != heater};
        res.temp      = held_t;
        res.hum       = held_h;
        res.co2       = held_c;
        return res;
    endfunction

    task automatic compare_field(input string label, input int want, input int got);
        if (want != got)
        begin
            $display("%0t: %s expected %0d actual %0d", $time, label, want, got);
            errs++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        actuation_t want;
        if (!rst_n)
        begin
            pending_actuations.delete();
            errs         = 0;
            t_lo         = RST_MIN_TEMP;
            t_hi         = RST_MAX_TEMP;
            h_lo         = RST_MIN_HUM;
            h_hi         = RST_MAX_HUM;
            c_lo         = RST_MIN_CO2;
            c_hi         = RST_MAX_CO2;
            persist_need = RST_PERSIST;
            {heater, cooler, irrigator, injector} = '0;
            {t_run, h_run, c_run} = '0;
            held_t = '0;
            held_h = '0;
            held_c = '0;
            mismatch_count <= 0;
            outstanding    <= 0;
        end
        else
        begin
            // The result leaving now belongs to an older item than any entering now.
            if (m_tvalid && m_tready)
            begin
                if (pending_actuations.size() == 0)
                begin
                    $display("%0t: result item expected none, actual %h",
                             $time, m_tdata);
                    errs++;
                end
                else
                begin
                    want = pending_actuations.pop_front();
                    compare_field("heater_on", int'(want.heater), int'(m_tdata[0]));
                    compare_field("cooler_on", int'(want.cooler), int'(m_tdata[1]));
                    compare_field("irrigator_on", int'(want.irrigator), int'(m_tdata[2]));
                    compare_field("injector_on", int'(want.injector), int'(m_tdata[3]));
                    compare_field("switch_mask", int'(want.switched), int'(m_tdata[7:4]));
                    compare_field("recent_temperature", int'($signed(want.temp)),
                                  int'($signed(m_tdata[22:8])));
                    compare_field("recent_humidity", int'(want.hum), int'(m_tdata[36:23]));
                    compare_field("recent_co2", int'(want.co2), int'(m_tdata[53:37]));
                end
            end
            if (s_tvalid && s_tready)
                pending_actuations.push_back(predict_actuation(s_tuser, s_tdata[ReadW-1:0]));
            if (cfg_wr_en)
            begin
                case (cfg_addr)
                    REG_MIN_TEMP: t_lo = cfg_wdata[TempW-1:0];
                    REG_MAX_TEMP: t_hi = cfg_wdata[TempW-1:0];
                    REG_MIN_HUM:  h_lo = cfg_wdata[HumW-1:0];
                    REG_MAX_HUM:  h_hi = cfg_wdata[HumW-1:0];
                    REG_MIN_CO2:  c_lo = cfg_wdata[Co2W-1:0];
                    REG_MAX_CO2:  c_hi = cfg_wdata[Co2W-1:0];
                    REG_PERSIST:  persist_need = cfg_wdata[RunW-1:0];
                    default: ;
                endcase
            end
            mismatch_count <= errs;
            outstanding    <= pending_actuations.size();
        end
    end

endmodule

// ===== sim/testbench.sv =====
// Top of the greenhouse threshold controller testbench: clock, reset, sensor stimulus,
// configuration phases, receiver stalls, watchdog and verdict.
// Depends on gtc_pkg, actuator_checker and greenhouse_threshold_controller_top.
module testbench;
    import gtc_pkg::*;

    localparam int              WATCHDOG_LIMIT = 3000;
    localparam int              LONG_HOLD      = 300;
    localparam logic [1:0]      REQ_NONE       = 2'd3;
    localparam logic [CfgAddrW-1:0] REG_UNUSED = 3'd7;

    typedef enum int {
        MODE_LOW,
        MODE_HIGH,
        MODE_MID_RANGE,
        MODE_MIDPOINT,
        MODE_EDGE,
        MODE_NOISE
    } reading_mode_t;

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                s_tvalid  = 1'b0;
    logic                s_tready;
    logic [23:0]         s_tdata   = '0;
    logic [1:0]          s_tuser   = '0;
    logic                m_tvalid;
    logic                m_tready  = 1'b0;
    logic [55:0]         m_tdata;
    logic                cfg_wr_en = 1'b0;
    logic [CfgAddrW-1:0] cfg_addr  = '0;
    logic [CfgW-1:0]     cfg_wdata = '0;

    int mismatch_count;
    int outstanding;
    int idle_cycles = 0;

    bit tx_steady    = 1'b0;
    bit rx_steady    = 1'b0;
    bit hold_request = 1'b0;

    // Limits as the block sees them, indexed by sensor source.
    int lo_lim[3];
    int hi_lim[3];
    int persist_now;

    always #5 clk = ~clk;

    greenhouse_threshold_controller_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    actuator_checker u_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_addr       (cfg_addr),
        .cfg_wdata      (cfg_wdata),
        .mismatch_count (mismatch_count),
        .outstanding    (outstanding)
    );

    // Mostly short gaps, now and then a long one.
    function automatic int idle_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 55)
            return 0;
        if (p < 85)
            return $urandom_range(1, 3);
        if (p < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic reading_mode_t pick_mode();
        int p;
        p = $urandom_range(0, 99);
        if (p < 35)
            return MODE_LOW;
        if (p < 50)
            return MODE_HIGH;
        if (p < 65)
            return MODE_MID_RANGE;
        if (p < 75)
            return MODE_MIDPOINT;
        if (p < 85)
            return MODE_EDGE;
        return MODE_NOISE;
    endfunction

    function automatic int reading_for(logic [1:0] kind, reading_mode_t mode);
        int lo, hi, span;
        int v;
        if (kind == REQ_NONE || mode == MODE_NOISE)
        begin
            v = $urandom_range(0, 262143);
            return v - 131072;
        end
        lo   = lo_lim[kind];
        hi   = hi_lim[kind];
        span = (hi > lo) ? hi - lo : 0;
        case (mode)
            MODE_LOW:       v = lo - int'($urandom_range(1, 400));
            MODE_HIGH:      v = hi + int'($urandom_range(1, 400));
            MODE_MID_RANGE: v = lo + int'($urandom_range(0, span));
            MODE_MIDPOINT:  v = (lo + hi) / 2 + int'($urandom_range(0, 2)) - 1;
            default:        v = $urandom_range(0, 1) ? hi : lo;
        endcase
        return v;
    endfunction

    // Called at a falling edge; returns at a falling edge after the item is taken
    // and the following gap, with tvalid still high when there is no gap.
    task automatic send_reading(input logic [1:0] kind, input int value);
        int v;
        int gap;
        v = (value > 131071) ? 131071 : ((value < -131072) ? -131072 : value);
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {6'd0, 18'(v)};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
        gap = tx_steady ? 0 : idle_len();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            s_tuser  <= 2'($urandom);
            s_tdata  <= {6'd0, 18'($urandom)};
            repeat (gap) @(negedge clk);
        end
    endtask

    // Lowers tvalid and waits until every result item has come back.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(negedge clk);
        while (outstanding != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CfgAddrW-1:0] idx, input logic [CfgW-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        cfg_addr  <= 3'($urandom);
        cfg_wdata <= 17'($urandom);
        @(negedge clk);
    endtask

    task automatic program_limits(input logic [CfgW-1:0] tlo, input logic [CfgW-1:0] thi,
                                  input logic [CfgW-1:0] hlo, input logic [CfgW-1:0] hhi,
                                  input logic [CfgW-1:0] clo, input logic [CfgW-1:0] chi,
                                  input logic [CfgW-1:0] pc);
        write_reg(REG_MIN_TEMP, tlo);
        write_reg(REG_MAX_TEMP, thi);
        write_reg(REG_MIN_HUM, hlo);
        write_reg(REG_MAX_HUM, hhi);
        write_reg(REG_MIN_CO2, clo);
        write_reg(REG_MAX_CO2, chi);
        write_reg(REG_PERSIST, pc);
        lo_lim[0]   = int'($signed(tlo[TempW-1:0]));
        hi_lim[0]   = int'($signed(thi[TempW-1:0]));
        lo_lim[1]   = int'(hlo[HumW-1:0]);
        hi_lim[1]   = int'(hhi[HumW-1:0]);
        lo_lim[2]   = int'(clo[Co2W-1:0]);
        hi_lim[2]   = int'(chi[Co2W-1:0]);
        persist_now = int'(pc[RunW-1:0]);
    endtask

    task automatic random_limits();
        int ta, tb, ha, hb, ca, cb, sw, pc;
        ta = int'($urandom_range(0, 20000)) - 10000;
        tb = int'($urandom_range(0, 20000)) - 10000;
        ha = $urandom_range(0, 10000);
        hb = $urandom_range(0, 10000);
        ca = $urandom_range(0, 100000);
        cb = $urandom_range(0, 100000);
        // Mostly ordered limits; the rest stay inverted.
        if (ta > tb && $urandom_range(0, 4) != 0)
        begin
            sw = ta; ta = tb; tb = sw;
        end
        if (ha > hb && $urandom_range(0, 4) != 0)
        begin
            sw = ha; ha = hb; hb = sw;
        end
        if (ca > cb && $urandom_range(0, 4) != 0)
        begin
            sw = ca; ca = cb; cb = sw;
        end
        pc = ($urandom_range(0, 5) == 0) ? $urandom_range(7, 20) : $urandom_range(1, 6);
        program_limits(17'(ta), 17'(tb), 17'(ha), 17'(hb), 17'(ca), 17'(cb), 17'(pc));
    endtask

    // Bursts of readings on one source, so that runs reach the persist count;
    // a few items inside each burst break the pattern.
    task automatic run_phase(input int count);
        int            sent, burst, k;
        logic [1:0]    kind;
        reading_mode_t mode;
        sent = 0;
        while (sent < count)
        begin
            kind  = ($urandom_range(0, 99) < 4) ? REQ_NONE : 2'($urandom_range(0, 2));
            mode  = pick_mode();
            burst = $urandom_range(1, (persist_now > 18) ? 20 : persist_now + 2);
            for (k = 0; k < burst && sent < count; k++)
            begin
                send_reading(kind, reading_for(kind,
                             ($urandom_range(0, 99) < 85) ? mode : pick_mode()));
                sent++;
            end
        end
    endtask

    // Receiver: random stalls, plus one long hold-off when asked for.
    initial
    begin
        int stall;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (hold_request)
            begin
                hold_request = 1'b0;
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
            end
            else
            begin
                stall = rx_steady ? 0 : idle_len();
                if (stall > 0)
                begin
                    m_tready <= 1'b0;
                    repeat (stall) @(negedge clk);
                end
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(negedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            idle_cycles <= 0;
        else if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAIL greenhouse_threshold_controller_top");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        int i;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: each actuator on and off, saturation of the held readings.
        program_limits(17'd1500, 17'd3500, 17'd1500, 17'd3500, 17'd3000, 17'd6000, 17'd2);
        send_reading(REQ_TEMP, 2000);
        send_reading(REQ_TEMP, 4000);
        send_reading(REQ_TEMP, 4000);
        send_reading(REQ_TEMP, 3000);
        send_reading(REQ_TEMP, 2400);
        send_reading(REQ_TEMP, 1000);
        send_reading(REQ_TEMP, 1000);
        send_reading(REQ_TEMP, 2600);
        send_reading(REQ_TEMP, 131071);
        send_reading(REQ_TEMP, -131072);
        send_reading(REQ_HUM, 1000);
        send_reading(REQ_HUM, 1000);
        send_reading(REQ_HUM, 3000);
        send_reading(REQ_HUM, -1);
        send_reading(REQ_HUM, 131071);
        send_reading(REQ_CO2, 100);
        send_reading(REQ_CO2, 100);
        send_reading(REQ_CO2, 5000);
        send_reading(REQ_CO2, -131072);
        send_reading(REQ_CO2, 131071);
        send_reading(REQ_NONE, reading_for(REQ_NONE, MODE_NOISE));
        send_reading(REQ_NONE, -1);

        // Persist count of zero with inverted humidity limits: on and off in one step.
        wait_idle();
        program_limits(17'd1500, 17'd3500, 17'd5000, 17'd0, 17'd3000, 17'd6000, 17'd0);
        write_reg(REG_UNUSED, 17'($urandom));
        send_reading(REQ_HUM, 3000);
        send_reading(REQ_HUM, 1000);
        send_reading(REQ_TEMP, 1000);

        // Widest legal limits.
        wait_idle();
        program_limits(17'(-10000), 17'd10000, 17'd0, 17'd10000, 17'd0, 17'd100000, 17'd1);
        run_phase(25);

        // Every register at all ones: persist count 255, nearly every reading a low CO2 one.
        wait_idle();
        program_limits('1, '1, '1, '1, '1, '1, '1);
        for (i = 0; i < 290; i++)
        begin
            if ($urandom_range(0, 9) == 0)
                send_reading(2'($urandom_range(0, 1)), reading_for(REQ_NONE, MODE_NOISE));
            else
                send_reading(REQ_CO2, reading_for(REQ_CO2, MODE_LOW));
        end

        // Every register at zero.
        wait_idle();
        program_limits('0, '0, '0, '0, '0, '0, '0);
        run_phase(20);

        for (i = 0; i < 6; i++)
        begin
            wait_idle();
            random_limits();
            tx_steady = (i == 1);
            rx_steady = (i == 2);
            if (i == 3)
            begin
                // Start offering items only once the receiver has begun its hold-off.
                hold_request = 1'b1;
                while (hold_request)
                    @(negedge clk);
            end
            run_phase(25);
        end
        tx_steady = 1'b0;
        rx_steady = 1'b0;

        wait_idle();
        repeat (8) @(negedge clk);
        if (mismatch_count == 0 && outstanding == 0)
            $display("PASS greenhouse_threshold_controller_top");
        else
            $display("FAIL greenhouse_threshold_controller_top");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/gtc_pkg.sv
rtl/gtc_low_chan.sv
rtl/greenhouse_threshold_controller_top.sv
sim/actuator_checker.sv
sim/testbench.sv
